// ----- hw/rtl/nhr_pkg.sv -----
// ----------------------------------------------------------------------------
// nhr_pkg
// Shared types, field layout and ones' complement helpers for the NAT flow
// header rewrite core.
// ----------------------------------------------------------------------------
package nhr_pkg;

  // protocol numbers and tcp details
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] TCP_MIN_LEN = 16'd18;
  localparam int          FLAG_FIN    = 0;
  localparam int          FLAG_SYN    = 1;
  localparam int          FLAG_RST    = 2;

  // stream widths
  localparam int IN_W   = 72;
  localparam int OUT_W  = 136;
  localparam int CFG_W  = 32;
  localparam int CFG_IW = 3;

  // output field positions
  localparam int OUT_SRC_LO = 0;
  localparam int OUT_DST_LO = 32;
  localparam int OUT_SP_LO  = 64;
  localparam int OUT_DP_LO  = 80;
  localparam int OUT_REW    = 96;
  localparam int OUT_IPC_LO = 97;
  localparam int OUT_L4C_LO = 113;
  localparam int OUT_FDONE  = 129;
  localparam int OUT_RDONE  = 130;
  localparam int OUT_USED   = 131;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_ORIG_SRC_ADDR = 3'd0,
    REG_ORIG_DST_ADDR = 3'd1,
    REG_ORIG_SRC_PORT = 3'd2,
    REG_ORIG_DST_PORT = 3'd3,
    REG_NEW_SRC_ADDR  = 3'd4,
    REG_NEW_DST_ADDR  = 3'd5,
    REG_NEW_SRC_PORT  = 3'd6,
    REG_NEW_DST_PORT  = 3'd7
  } cfg_reg_t;

  // flow tuples plus the precomputed complemented deltas
  typedef struct packed {
    logic [31:0] orig_src_addr;
    logic [31:0] orig_dst_addr;
    logic [15:0] orig_src_port;
    logic [15:0] orig_dst_port;
    logic [31:0] new_src_addr;
    logic [31:0] new_dst_addr;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic [15:0] ip_delta;
    logic [15:0] l4_delta;
  } flow_cfg_t;

  // fold one changed word into a complemented delta
  function automatic logic [15:0] delta_word(input logic [15:0] c,
                                             input logic [15:0] oldw,
                                             input logic [15:0] neww);
    logic [17:0] s;
    logic [16:0] f;
    logic [16:0] g;
    s = {2'b00, ~c} + {2'b00, ~oldw} + {2'b00, neww};
    f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    g = f + {16'd0, f[16]};
    return ~g[15:0];
  endfunction

  // add (forward) or subtract (reply) a delta; a zero delta leaves it alone
  function automatic logic [15:0] apply_delta(input logic [15:0] csum,
                                              input logic        reply,
                                              input logic [15:0] d);
    logic [16:0] s;
    logic [16:0] f;
    logic [16:0] g;
    s = {1'b0, ~csum} + {1'b0, (reply ? d : ~d)};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    g = f + {16'd0, f[16]};
    return (d == 16'd0) ? csum : ~g[15:0];
  endfunction

endpackage

// ----- hw/rtl/nat_flow_header_rewrite_core.sv -----
// ----------------------------------------------------------------------------
// nat_flow_header_rewrite_core
// Rewrites addresses, ports and checksums of packets in one NAT flow and
// tracks the per-direction session-done flags.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata header fields, s_tuser dir
//  m_*     | out | m_tvalid / m_tready  | m_tdata rewritten header fields
//  cfg_*   | in  | cfg_we               | cfg_index, cfg_wdata
//
// one request accepted per cycle unless m_tready stalls; a result is
// presented after passing the input register, then the result register.
// the checksum deltas are registered in the cycle after a configuration write.
// synchronous reset clears the stage valids, done flags and config registers.
// a stall on m_tready holds the result register; the input stage keeps
// accepting until both stages are full.
// ----------------------------------------------------------------------------
module nat_flow_header_rewrite_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // first_fragment, protocol[8], segment_len[16], ip_checksum_in[16],
  // l4_checksum_in[16], tcp_flags[8], zero fill
  input  logic [nhr_pkg::IN_W-1:0]   s_tdata,
  // reply_dir
  input  logic [0:0]                 s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_src_addr[32], out_dst_addr[32], out_src_port[16], out_dst_port[16],
  // ports_rewritten, ip_checksum_out[16], l4_checksum_out[16],
  // forward_done_out, reply_done_out, zero fill
  output logic [nhr_pkg::OUT_W-1:0]  m_tdata,
  input  logic                       cfg_we,
  input  logic [nhr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nhr_pkg::CFG_W-1:0]  cfg_wdata
);
  import nhr_pkg::*;

  flow_cfg_t flow_cfg;

  // input stage
  logic        s1_valid;
  logic        s1_reply;
  logic        s1_first;
  logic [7:0]  s1_proto;
  logic [15:0] s1_tlen;
  logic [15:0] s1_ipck;
  logic [15:0] s1_l4ck;
  logic [7:0]  s1_flags;

  // result stage
  logic              o_valid;
  logic [OUT_W-1:0]  o_data;
  logic [OUT_W-1:0]  o_data_next;

  logic [1:0]  done_flags;
  logic [1:0]  done_flags_next;
  logic        advance;
  logic        tcp_ok;
  logic        udp_ok;
  logic        rew;
  logic [1:0]  dir_bit;
  logic [31:0] sa;
  logic [31:0] da;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [15:0] ipck_out;
  logic [15:0] l4ck_out;

  nhr_cfg_delta u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .flow_cfg  (flow_cfg)
  );

  // handshake
  assign advance  = !o_valid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_reply <= s_tuser[0];
      s1_first <= s_tdata[0];
      s1_proto <= s_tdata[8:1];
      s1_tlen  <= s_tdata[24:9];
      s1_ipck  <= s_tdata[40:25];
      s1_l4ck  <= s_tdata[56:41];
      s1_flags <= s_tdata[64:57];
    end
  end

  // rewrite and checksum update
  always_comb begin
    tcp_ok  = s1_first && (s1_proto == PROTO_TCP) && (s1_tlen >= TCP_MIN_LEN);
    udp_ok  = s1_first && (s1_proto == PROTO_UDP);
    rew     = tcp_ok || udp_ok;
    dir_bit = s1_reply ? 2'b10 : 2'b01;

    if (s1_reply) begin
      sa = flow_cfg.orig_dst_addr;
      da = flow_cfg.orig_src_addr;
      sp = flow_cfg.orig_dst_port;
      dp = flow_cfg.orig_src_port;
    end else begin
      sa = flow_cfg.new_src_addr;
      da = flow_cfg.new_dst_addr;
      sp = flow_cfg.new_src_port;
      dp = flow_cfg.new_dst_port;
    end

    ipck_out = apply_delta(s1_ipck, s1_reply, flow_cfg.ip_delta);
    // udp zero checksum means no checksum and is passed through
    if (tcp_ok || (udp_ok && (s1_l4ck != 16'd0))) begin
      l4ck_out = apply_delta(s1_l4ck, s1_reply, flow_cfg.l4_delta);
    end else begin
      l4ck_out = s1_l4ck;
    end

    // session flags: reset ends both sides, fin ends one, syn reopens it
    done_flags_next = done_flags;
    if (tcp_ok) begin
      if (s1_flags[FLAG_RST]) begin
        done_flags_next = 2'b11;
      end else if (s1_flags[FLAG_FIN]) begin
        done_flags_next = done_flags | dir_bit;
      end else if (s1_flags[FLAG_SYN]) begin
        done_flags_next = done_flags & ~dir_bit;
      end
    end

    o_data_next                           = '0;
    o_data_next[OUT_SRC_LO +: 32]         = sa;
    o_data_next[OUT_DST_LO +: 32]         = da;
    o_data_next[OUT_SP_LO  +: 16]         = rew ? sp : 16'd0;
    o_data_next[OUT_DP_LO  +: 16]         = rew ? dp : 16'd0;
    o_data_next[OUT_REW]                  = rew;
    o_data_next[OUT_IPC_LO +: 16]         = ipck_out;
    o_data_next[OUT_L4C_LO +: 16]         = l4ck_out;
    o_data_next[OUT_FDONE]                = done_flags_next[0];
    o_data_next[OUT_RDONE]                = done_flags_next[1];
  end

  // result register and done flags
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      done_flags <= 2'b00;
    end else if (advance) begin
      o_valid <= s1_valid;
      if (s1_valid) begin
        done_flags <= done_flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      o_data <= o_data_next;
    end
  end

endmodule

// ----- hw/rtl/nhr_cfg_delta.sv -----
// ----------------------------------------------------------------------------
// nhr_cfg_delta
// Flow configuration registers and the registered IP and transport checksum
// deltas derived from them.
// ----------------------------------------------------------------------------
module nhr_cfg_delta (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [nhr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nhr_pkg::CFG_W-1:0]  cfg_wdata,
  output nhr_pkg::flow_cfg_t         flow_cfg
);
  import nhr_pkg::*;

  flow_cfg_t   cfg;
  logic [19:0] ip_sum;
  logic [19:0] l4_sum;
  logic [16:0] ip_fold;
  logic [16:0] l4_fold;
  logic [15:0] ip_delta_next;
  logic [15:0] l4_delta_next;

  // register writes; deltas follow the tuples in the cycle after they change
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orig_src_addr <= '0;
      cfg.orig_dst_addr <= '0;
      cfg.orig_src_port <= '0;
      cfg.orig_dst_port <= '0;
      cfg.new_src_addr  <= '0;
      cfg.new_dst_addr  <= '0;
      cfg.new_src_port  <= '0;
      cfg.new_dst_port  <= '0;
      cfg.ip_delta      <= '0;
      cfg.l4_delta      <= '0;
    end else begin
      cfg.ip_delta <= ip_delta_next;
      cfg.l4_delta <= l4_delta_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ORIG_SRC_ADDR: cfg.orig_src_addr <= cfg_wdata;
          REG_ORIG_DST_ADDR: cfg.orig_dst_addr <= cfg_wdata;
          REG_ORIG_SRC_PORT: cfg.orig_src_port <= cfg_wdata[15:0];
          REG_ORIG_DST_PORT: cfg.orig_dst_port <= cfg_wdata[15:0];
          REG_NEW_SRC_ADDR:  cfg.new_src_addr  <= cfg_wdata;
          REG_NEW_DST_ADDR:  cfg.new_dst_addr  <= cfg_wdata;
          REG_NEW_SRC_PORT:  cfg.new_src_port  <= cfg_wdata[15:0];
          REG_NEW_DST_PORT:  cfg.new_dst_port  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // one wide sum over all changed words, then an end-around fold; this
  // equals folding the address words then the port words one at a time
  always_comb begin
    ip_sum = 20'h0FFFF
           + {4'd0, ~cfg.orig_src_addr[31:16]} + {4'd0, cfg.new_src_addr[31:16]}
           + {4'd0, ~cfg.orig_src_addr[15:0]}  + {4'd0, cfg.new_src_addr[15:0]}
           + {4'd0, ~cfg.orig_dst_addr[31:16]} + {4'd0, cfg.new_dst_addr[31:16]}
           + {4'd0, ~cfg.orig_dst_addr[15:0]}  + {4'd0, cfg.new_dst_addr[15:0]};
    l4_sum = ip_sum
           + {4'd0, ~cfg.orig_src_port} + {4'd0, cfg.new_src_port}
           + {4'd0, ~cfg.orig_dst_port} + {4'd0, cfg.new_dst_port};
    ip_fold       = {1'b0, ip_sum[15:0]} + {13'd0, ip_sum[19:16]};
    l4_fold       = {1'b0, l4_sum[15:0]} + {13'd0, l4_sum[19:16]};
    ip_delta_next = ~(ip_fold[15:0] + {15'd0, ip_fold[16]});
    l4_delta_next = ~(l4_fold[15:0] + {15'd0, l4_fold[16]});
  end

  assign flow_cfg = cfg;

endmodule

// ----- hw/rtl/nhr_checker.sv -----
// ----------------------------------------------------------------------------
// nhr_checker
// Port-level checks for the NAT flow header rewrite core, bound to the top.
// ----------------------------------------------------------------------------
module nhr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [nhr_pkg::OUT_W-1:0]  m_tdata
);
  import nhr_pkg::*;

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // with an empty result register the input side must be open
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output empty");

  // ports read zero when not rewritten, fill bits always zero
  a_ports: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_REW] || m_tdata[OUT_DP_LO+15:OUT_SP_LO] == 32'd0)
                 && m_tdata[OUT_W-1:OUT_USED] == '0)
    else $error("stray port or fill bits");

endmodule

bind nat_flow_header_rewrite_core nhr_checker u_nhr_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NAT flow header rewrite core. Header requests
// are streamed in under random source and sink idling, and every rewritten
// header is checked field by field against a cycle-free predictor of the
// address/port rewrite, the incremental checksum update and the two
// session-done flags. The flow tuple is reloaded between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nhr_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int N_PHASES      = 6;
  localparam int RANDOM_PER_PH = 300;
  localparam int HOLD_AT_REQ   = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 400000;

  // one rewritten header as the block should present it
  typedef struct {
    bit [31:0] src_addr;
    bit [31:0] dst_addr;
    bit [15:0] src_port;
    bit [15:0] dst_port;
    bit        rewritten;
    bit [15:0] ip_csum;
    bit [15:0] l4_csum;
    bit        fwd_done;
    bit        rply_done;
  } rewrite_t;

  // flow tuple, done flags and the queue of rewrites still owed by the block
  class rewrite_tracker;
    bit [31:0] flow_reg [8];
    bit [1:0]  done_flags;
    rewrite_t  expected_rewrites [$];
    int        errors;
    int        n_requests;

    function new();
      foreach (flow_reg[i]) flow_reg[i] = '0;
      done_flags = 2'b00;
      errors     = 0;
      n_requests = 0;
    endfunction

    function void set_reg(cfg_reg_t r, bit [31:0] v);
      flow_reg[r] = v;
    endfunction

    function int pending();
      return expected_rewrites.size();
    endfunction

    // add (new - old) of one word into a complemented running delta
    function bit [15:0] fold_word(bit [15:0] acc, bit [15:0] was, bit [15:0] now);
      bit [17:0] total;
      total = {2'b00, ~acc} + {2'b00, ~was} + {2'b00, now};
      total = {2'b00, total[15:0]} + {16'd0, total[17:16]};
      total = {2'b00, total[15:0]} + {16'd0, total[17:16]};
      return ~total[15:0];
    endfunction

    // forward adds the delta, reply takes it away; no net change passes through
    function bit [15:0] adjust_sum(bit [15:0] csum, bit reply, bit [15:0] d);
      bit [16:0] total;
      if (d == 16'd0) return csum;
      total = {1'b0, ~csum} + {1'b0, (reply ? d : ~d)};
      total = {1'b0, total[15:0]} + {16'd0, total[16]};
      total = {1'b0, total[15:0]} + {16'd0, total[16]};
      return ~total[15:0];
    endfunction

    // work out the rewrite of one accepted request
    function void note_request(bit reply, logic [IN_W-1:0] raw);
      bit        first;
      bit [7:0]  proto;
      bit [15:0] tlen;
      bit [15:0] ipck;
      bit [15:0] l4ck;
      bit [7:0]  flags;
      bit [31:0] osa, oda, nsa, nda;
      bit [15:0] osp, odp, nsp, ndp;
      bit [15:0] ip_delta;
      bit [15:0] l4_delta;
      bit [1:0]  dir_mask;
      rewrite_t  res;
      first = raw[0];
      proto = raw[8:1];
      tlen  = raw[24:9];
      ipck  = raw[40:25];
      l4ck  = raw[56:41];
      flags = raw[64:57];
      osa = flow_reg[REG_ORIG_SRC_ADDR];
      oda = flow_reg[REG_ORIG_DST_ADDR];
      osp = flow_reg[REG_ORIG_SRC_PORT][15:0];
      odp = flow_reg[REG_ORIG_DST_PORT][15:0];
      nsa = flow_reg[REG_NEW_SRC_ADDR];
      nda = flow_reg[REG_NEW_DST_ADDR];
      nsp = flow_reg[REG_NEW_SRC_PORT][15:0];
      ndp = flow_reg[REG_NEW_DST_PORT][15:0];
      // address words high then low, ports on top for the transport delta
      ip_delta = fold_word(16'd0, osa[31:16], nsa[31:16]);
      ip_delta = fold_word(ip_delta, osa[15:0], nsa[15:0]);
      ip_delta = fold_word(ip_delta, oda[31:16], nda[31:16]);
      ip_delta = fold_word(ip_delta, oda[15:0], nda[15:0]);
      l4_delta = fold_word(ip_delta, osp, nsp);
      l4_delta = fold_word(l4_delta, odp, ndp);
      dir_mask = reply ? 2'b10 : 2'b01;

      res.src_addr  = reply ? oda : nsa;
      res.dst_addr  = reply ? osa : nda;
      res.src_port  = 16'd0;
      res.dst_port  = 16'd0;
      res.rewritten = 1'b0;
      res.ip_csum   = adjust_sum(ipck, reply, ip_delta);
      res.l4_csum   = l4ck;

      if (first && proto == PROTO_TCP && tlen >= TCP_MIN_LEN) begin
        res.rewritten = 1'b1;
        res.src_port  = reply ? odp : nsp;
        res.dst_port  = reply ? osp : ndp;
        res.l4_csum   = adjust_sum(l4ck, reply, l4_delta);
        // reset ends both sides, fin ends this side, syn reopens it
        if (flags[FLAG_RST]) begin
          done_flags = 2'b11;
        end else if (flags[FLAG_FIN]) begin
          done_flags = done_flags | dir_mask;
        end else if (flags[FLAG_SYN]) begin
          done_flags = done_flags & ~dir_mask;
        end
      end else if (first && proto == PROTO_UDP) begin
        res.rewritten = 1'b1;
        res.src_port  = reply ? odp : nsp;
        res.dst_port  = reply ? osp : ndp;
        // a zero udp checksum means none was sent
        if (l4ck != 16'd0) res.l4_csum = adjust_sum(l4ck, reply, l4_delta);
      end

      res.fwd_done  = done_flags[0];
      res.rply_done = done_flags[1];
      expected_rewrites.insert(expected_rewrites.size(), res);
      n_requests++;
    endfunction

    function void compare_field(string name, bit [31:0] want, bit [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    // match one rewritten header against the oldest owed rewrite
    function void check_result(logic [OUT_W-1:0] raw);
      rewrite_t want;
      if (expected_rewrites.size() == 0) begin
        $error("rewritten header with none outstanding: %h", raw);
        errors++;
        return;
      end
      want = expected_rewrites.pop_front();
      compare_field("out_src_addr", want.src_addr, raw[OUT_SRC_LO +: 32]);
      compare_field("out_dst_addr", want.dst_addr, raw[OUT_DST_LO +: 32]);
      compare_field("out_src_port", 32'(want.src_port), 32'(raw[OUT_SP_LO +: 16]));
      compare_field("out_dst_port", 32'(want.dst_port), 32'(raw[OUT_DP_LO +: 16]));
      compare_field("ports_rewritten", 32'(want.rewritten), 32'(raw[OUT_REW]));
      compare_field("ip_checksum_out", 32'(want.ip_csum), 32'(raw[OUT_IPC_LO +: 16]));
      compare_field("l4_checksum_out", 32'(want.l4_csum), 32'(raw[OUT_L4C_LO +: 16]));
      compare_field("forward_done_out", 32'(want.fwd_done), 32'(raw[OUT_FDONE]));
      compare_field("reply_done_out", 32'(want.rply_done), 32'(raw[OUT_RDONE]));
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;
  logic [0:0]        s_tuser   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we    = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  rewrite_tracker tracker = new();
  int  snd_gap_pct = 0;
  int  rcv_gap_pct = 0;
  int  cycles      = 0;

  nat_flow_header_rewrite_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // note each accepted request
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.note_request(s_tuser[0], s_tdata);
  end

  // check each accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // sink: random back-pressure, plus one long hold-off once the flow is busy
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && tracker.n_requests >= HOLD_AT_REQ) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rcv_gap_pct);
    end
  end

  // offer one request and hold it until taken
  task automatic send_request(bit reply, bit first, bit [7:0] proto, bit [15:0] tlen,
                              bit [15:0] ipck, bit [15:0] l4ck, bit [7:0] flags);
    while ($urandom_range(99) < snd_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= reply;
    s_tdata  <= {7'd0, flags, l4ck, ipck, tlen, proto, first};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mostly well-formed tcp and udp with random content, some other traffic
  task automatic send_random();
    int        pick;
    bit [7:0]  proto;
    bit [15:0] tlen;
    bit [7:0]  flags;
    bit [15:0] l4ck;
    pick = $urandom_range(9);
    if (pick < 4) proto = PROTO_TCP;
    else if (pick < 7) proto = PROTO_UDP;
    else proto = 8'($urandom_range(255));
    tlen = ($urandom_range(7) == 0) ? 16'($urandom_range(17)) : 16'($urandom_range(65535));
    case ($urandom_range(7))
      0: flags = 8'(1 << FLAG_FIN);
      1: flags = 8'(1 << FLAG_SYN);
      2: flags = 8'(1 << FLAG_RST);
      3: flags = 8'((1 << FLAG_FIN) | (1 << FLAG_SYN));
      default: flags = 8'($urandom_range(255));
    endcase
    l4ck = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65535));
    send_request(1'($urandom_range(1)), $urandom_range(9) != 0, proto, tlen,
                 16'($urandom_range(65535)), l4ck, flags);
  endtask

  // load the whole flow tuple while the core is idle
  task automatic write_flow(bit [31:0] tuple [8]);
    cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= tuple[r];
      tracker.set_reg(r, tuple[r]);
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    // give the delta registers time to settle
    repeat (3) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    bit [31:0] tuple [8];
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // idling pattern per pair of phases
      if (ph < 2) begin
        snd_gap_pct = 30;
        rcv_gap_pct = 46;
      end else if (ph < 4) begin
        snd_gap_pct = 46;
        rcv_gap_pct = 30;
      end else begin
        snd_gap_pct = 0;
        rcv_gap_pct = 0;
      end

      // flow tuple for this phase
      foreach (tuple[i]) tuple[i] = $urandom();
      case (ph)
        1: foreach (tuple[i]) tuple[i] = 32'hFFFF_FFFF;
        2: foreach (tuple[i]) tuple[i] = 32'h0;
        3: begin
          tuple[REG_NEW_SRC_ADDR] = tuple[REG_ORIG_SRC_ADDR];
          tuple[REG_NEW_DST_ADDR] = tuple[REG_ORIG_DST_ADDR];
          tuple[REG_NEW_SRC_PORT] = tuple[REG_ORIG_SRC_PORT];
          tuple[REG_NEW_DST_PORT] = tuple[REG_ORIG_DST_PORT];
        end
        5: begin
          // addresses kept, only ports translated
          tuple[REG_NEW_SRC_ADDR] = tuple[REG_ORIG_SRC_ADDR];
          tuple[REG_NEW_DST_ADDR] = tuple[REG_ORIG_DST_ADDR];
        end
        default: ;
      endcase
      write_flow(tuple);

      if (ph == 0) begin
        // tcp session flag walk
        send_request(1'b0, 1'b1, PROTO_TCP, TCP_MIN_LEN, 16'h1234, 16'h5678, 8'(1 << FLAG_SYN));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd40, 16'hABCD, 16'h0F0F, 8'(1 << FLAG_SYN));
        send_request(1'b0, 1'b1, PROTO_TCP, 16'd60, 16'h0001, 16'h8000, 8'(1 << FLAG_FIN));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd60, 16'hFFFE, 16'h7FFF, 8'(1 << FLAG_FIN));
        send_request(1'b0, 1'b1, PROTO_TCP, 16'd20, 16'h4321, 16'h1111, 8'(1 << FLAG_SYN));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd20, 16'h2222, 16'h3333, 8'(1 << FLAG_RST));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd20, 16'h4444, 16'h5555, 8'(1 << FLAG_SYN));
        send_request(1'b0, 1'b1, PROTO_TCP, 16'd20, 16'h6666, 16'h7777, 8'hFF);
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd20, 16'h8888, 16'h9999,
                     8'((1 << FLAG_FIN) | (1 << FLAG_SYN)));
        // short tcp behaves like an unknown protocol
        send_request(1'b0, 1'b1, PROTO_TCP, TCP_MIN_LEN - 16'd1, 16'hAAAA, 16'hBBBB,
                     8'(1 << FLAG_RST));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd0, 16'hCCCC, 16'hDDDD, 8'(1 << FLAG_SYN));
        send_request(1'b0, 1'b1, PROTO_TCP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
        // udp, with and without a checksum
        send_request(1'b0, 1'b1, PROTO_UDP, 16'd8, 16'h0F00, 16'h0000, 8'h00);
        send_request(1'b1, 1'b1, PROTO_UDP, 16'd8, 16'hF00F, 16'h0000, 8'hFF);
        send_request(1'b1, 1'b1, PROTO_UDP, 16'd100, 16'h0000, 16'hFFFF, 8'h00);
        send_request(1'b0, 1'b1, PROTO_UDP, 16'd0, 16'h1357, 16'h2468, 8'h00);
        // later fragments get no port rewrite and leave the done flags alone
        send_request(1'b0, 1'b0, PROTO_TCP, 16'd60, 16'h9753, 16'h8642, 8'(1 << FLAG_RST));
        send_request(1'b1, 1'b0, PROTO_UDP, 16'd60, 16'hFFFF, 16'h0001, 8'h00);
        // other protocols, then two more tcp segments
        send_request(1'b0, 1'b1, 8'd0, 16'd0, 16'h0000, 16'h0000, 8'h00);
        send_request(1'b1, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(1'b0, 1'b1, 8'd1, 16'd64, 16'hFFFF, 16'h0000, 8'(1 << FLAG_RST));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd20, 16'h0000, 16'h0000, 8'(1 << FLAG_SYN));
        send_request(1'b1, 1'b1, PROTO_TCP, 16'd20, 16'h5A5A, 16'hA5A5, 8'h00);
      end

      repeat (RANDOM_PER_PH) send_random();
      drain();
    end

    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/nhr_pkg.sv
hw/rtl/nhr_cfg_delta.sv
hw/rtl/nat_flow_header_rewrite_core.sv
hw/rtl/nhr_checker.sv
test/testbench.sv
